FILE: hw/rtl/delimited_command_deframer_assert.svh
// Assertion macros shared by the deframer checker.
`ifndef DELIMITED_COMMAND_DEFRAMER_ASSERT_SVH
`define DELIMITED_COMMAND_DEFRAMER_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define DCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, off while reset is high
`define DCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

FILE: hw/rtl/dcd_pkg.sv
// Package: types and constants of the delimited command deframer.
`timescale 1ns / 1ps

package dcd_pkg;

  // Default frame capacity; the store holds one byte less
  localparam int CMD_CAPACITY = 32;

  // Widest byte count over the supported capacity range (up to 128)
  localparam int CNT_MAX_W = 7;

  // Framing characters
  localparam logic [7:0] START_CHAR = 8'h40;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] LF_CHAR    = 8'h0A;

  // Parser phase; code 3 is unused and acts as idle
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_TERM = 2'd2
  } phase_t;

  // Playout sequencer state
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_FETCH = 2'd1,
    BK_SHOW  = 2'd2
  } back_state_t;

  // One completed command: buffer bank and payload length
  typedef struct packed {
    logic                 bank;
    logic [CNT_MAX_W-1:0] count;
  } cmd_desc_t;

endpackage

FILE: hw/rtl/dcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/dcd_front.sv
// Front end: frame parser that fills the payload buffer and queues commands.
`timescale 1ns / 1ps

module dcd_front #(
  parameter int CMD_CAPACITY = dcd_pkg::CMD_CAPACITY,
  localparam int SD = CMD_CAPACITY - 1,
  localparam int IW = (SD > 1) ? $clog2(SD) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] rx_byte
  input  logic                q_full,
  output logic                q_push,
  output dcd_pkg::cmd_desc_t  q_desc,
  output logic                wr_en,
  output logic [IW:0]         wr_addr,
  output logic [7:0]          wr_data
);

  localparam int CW = $clog2(CMD_CAPACITY);

  dcd_pkg::phase_t phase, phase_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic            bank, bank_next;
  logic            accept;
  logic            is_cr;
  logic            has_room;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_cr    = (s_tdata == dcd_pkg::CR_CHAR);
  assign has_room = (cnt < CW'(SD));

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      dcd_pkg::PH_BODY: begin
        if (accept) begin
          if (is_cr) begin
            phase_next = dcd_pkg::PH_TERM;
          end else if (!has_room) begin
            phase_next = dcd_pkg::PH_IDLE;
          end
        end
      end
      dcd_pkg::PH_TERM: begin
        if (accept) begin
          phase_next = dcd_pkg::PH_IDLE;
        end
      end
      default: begin
        if (accept && s_tdata == dcd_pkg::START_CHAR) begin
          phase_next = dcd_pkg::PH_BODY;
        end else begin
          phase_next = dcd_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // Buffer write, command push and byte count
  always_comb begin
    wr_en    = accept && (phase == dcd_pkg::PH_BODY) && !is_cr && has_room;
    wr_addr  = {bank, cnt[IW-1:0]};
    wr_data  = s_tdata;
    q_push   = accept && (phase == dcd_pkg::PH_TERM) && (s_tdata == dcd_pkg::LF_CHAR);
    q_desc.bank  = bank;
    q_desc.count = dcd_pkg::CNT_MAX_W'(cnt);
    bank_next = bank ^ q_push;
    cnt_next  = cnt;
    if (wr_en) begin
      cnt_next = cnt + CW'(1);
    end else if (accept && !((phase == dcd_pkg::PH_BODY) && is_cr)) begin
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dcd_pkg::PH_IDLE;
      cnt   <= '0;
      bank  <= 1'b0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      bank  <= bank_next;
    end
  end

endmodule

FILE: hw/rtl/dcd_queue.sv
// Two-entry command queue between parser and playout; head stays until popped.
`timescale 1ns / 1ps

module dcd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dcd_pkg::cmd_desc_t push_desc,
  output logic               full,
  output logic               valid,
  output dcd_pkg::cmd_desc_t head,
  input  logic               pop
);

  dcd_pkg::cmd_desc_t entry [2];
  logic               wptr, rptr;
  logic [1:0]         fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = entry[rptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_desc;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hw/rtl/dcd_back.sv
// Back end: plays a queued command out of the payload buffer onto the output stream.
`timescale 1ns / 1ps

module dcd_back #(
  parameter int CMD_CAPACITY = dcd_pkg::CMD_CAPACITY,
  localparam int SD = CMD_CAPACITY - 1,
  localparam int IW = (SD > 1) ? $clog2(SD) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  dcd_pkg::cmd_desc_t q_head,
  output logic               q_pop,
  output logic               rd_en,
  output logic [IW:0]        rd_addr,
  input  logic [7:0]         rd_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [7:0] cmd_byte
  output logic               m_tlast,   // last_byte
  output logic               m_tuser    // empty_command
);

  localparam int CW = $clog2(CMD_CAPACITY);

  dcd_pkg::back_state_t state, state_next;
  logic [IW-1:0]        rd_idx, rd_idx_next;
  logic                 is_empty;
  logic                 last;
  logic                 accept;

  assign is_empty = (q_head.count == '0);
  assign last     = is_empty || ((CW'(rd_idx) + CW'(1)) == q_head.count[CW-1:0]);
  assign accept   = m_tvalid && m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dcd_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = is_empty ? dcd_pkg::BK_SHOW : dcd_pkg::BK_FETCH;
        end
      end
      dcd_pkg::BK_FETCH: begin
        state_next = dcd_pkg::BK_SHOW;
      end
      dcd_pkg::BK_SHOW: begin
        if (accept && last) begin
          state_next = dcd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = dcd_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs, buffer reads and byte index
  always_comb begin
    m_tvalid = (state == dcd_pkg::BK_SHOW);
    m_tdata  = is_empty ? 8'h00 : rd_data;
    m_tlast  = last;
    m_tuser  = is_empty;
    q_pop    = accept && last;
    rd_en    = (state == dcd_pkg::BK_FETCH) ||
               ((state == dcd_pkg::BK_SHOW) && accept && !last);
    rd_addr  = {q_head.bank, (state == dcd_pkg::BK_FETCH) ? rd_idx : rd_idx + IW'(1)};
    rd_idx_next = rd_idx;
    if (state == dcd_pkg::BK_IDLE) begin
      rd_idx_next = '0;
    end else if ((state == dcd_pkg::BK_SHOW) && accept && !last) begin
      rd_idx_next = rd_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dcd_pkg::BK_IDLE;
      rd_idx <= '0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
    end
  end

endmodule

FILE: hw/rtl/delimited_command_deframer.sv
// Delimited command deframer: "@" ... CR LF frames in, command byte runs out.
// Input: one received byte per slave-side transaction (s_tdata).
// Output: one payload byte per master-side transaction, m_tlast on the final
// byte of a command; an empty command gives a single transaction with
// m_tuser high, m_tlast high and m_tdata zero.
// Input rate is one byte per cycle while the queue is not full. After its LF is
// accepted, a command passes the queue and the fetch state (skipped when empty),
// then streams one byte per cycle while m_tready is high; idle and fetch sit between commands.
// The payload buffer has two banks, so one command can be collected while
// the previous one is played out; a two-entry queue of finished commands
// sits between parser and playout.
// When the receiver stalls, the current output transaction holds; once two
// finished commands wait, s_tready drops until the older one is delivered.
// Reset returns the parser to waiting for "@" and empties the queue; the
// buffer contents are left as they are and are never read before written.
`timescale 1ns / 1ps

module delimited_command_deframer #(
  parameter int CMD_CAPACITY = dcd_pkg::CMD_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] cmd_byte
  output logic       m_tlast,   // last_byte
  output logic       m_tuser    // empty_command
);

  localparam int SD = CMD_CAPACITY - 1;
  localparam int IW = (SD > 1) ? $clog2(SD) : 1;

  dcd_pkg::cmd_desc_t push_desc, head;
  logic               push, pop, full, valid;
  logic               wr_en, rd_en;
  logic [IW:0]        wr_addr, rd_addr;
  logic [7:0]         wr_data, rd_data;

  dcd_front #(.CMD_CAPACITY(CMD_CAPACITY)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (full),
    .q_push   (push),
    .q_desc   (push_desc),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  dcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .valid     (valid),
    .head      (head),
    .pop       (pop)
  );

  dcd_ram #(.WIDTH(8), .DEPTH(2 ** (IW + 1))) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dcd_back #(.CMD_CAPACITY(CMD_CAPACITY)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (valid),
    .q_head   (head),
    .q_pop    (pop),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: hw/rtl/dcd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`timescale 1ns / 1ps
`include "delimited_command_deframer_assert.svh"

module dcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // A stalled output transaction holds its payload
  `DCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tlast, m_tuser}))

  // An empty command is a single zero byte that closes the command
  `DCD_ASSERT_NOW(a_empty_form, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00))

  // Inside a command, the next byte can never be an empty marker
  `DCD_ASSERT_NEXT(a_no_empty_mid, m_tvalid && m_tready && !m_tlast, !(m_tvalid && m_tuser))

  // Nothing is offered right after reset
  `DCD_ASSERT_NOW(a_quiet_after_rst, $fell(rst), !m_tvalid)

endmodule

bind delimited_command_deframer dcd_checker u_dcd_checker (.*);

FILE: dv/tb.sv
// Testbench for the delimited command deframer: random "@" ... CR LF streams, scoreboard check.
`timescale 1ns / 1ps

module tb;
  import dcd_pkg::*;

  localparam int STORE_DEPTH = CMD_CAPACITY - 1;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int SETTLE      = 16;    // cycles allowed after the last result
  localparam int LOG_CAP     = 60;    // stop printing mismatch lines past this

  // One byte on its way into the block
  typedef struct {
    logic [7:0] data;
    int         gap;     // cycles to hold off before presenting it
    bit         drain;   // wait until every pending command byte has come out
  } rx_item_t;

  // One command byte as it should leave the block
  typedef struct packed {
    logic [7:0] cmd;
    logic       last;
    logic       empty;
  } cmd_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  rx_item_t   rx_items[$];
  cmd_beat_t  beats_due[$];

  // Shadow copy of the parser
  phase_t     frame_phase = PH_IDLE;
  int         stored = 0;
  logic [7:0] payload[STORE_DEPTH];

  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         in_taken = 1'b0;
  bit         out_taken = 1'b0;
  bit         tx_calm = 1'b0;
  bit         sink_calm = 1'b0;
  int         sink_stall = 0;

  delimited_command_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < LOG_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advance the shadow parser by one received byte, queueing any command it releases
  function automatic void deframe_byte(logic [7:0] b);
    int n;
    cmd_beat_t beat;
    case (frame_phase)
      PH_BODY: begin
        if (b == CR_CHAR) begin
          frame_phase = PH_TERM;
        end else if (stored < STORE_DEPTH) begin
          payload[stored] = b;
          stored++;
        end else begin
          // overflow drops the frame
          frame_phase = PH_IDLE;
          stored = 0;
        end
      end
      PH_TERM: begin
        n = stored;
        frame_phase = PH_IDLE;
        stored = 0;
        if (b == LF_CHAR) begin
          if (n == 0) begin
            beat = '{cmd: 8'h00, last: 1'b1, empty: 1'b1};
            beats_due.push_back(beat);
          end else begin
            for (int k = 0; k < n; k++) begin
              beat = '{cmd: payload[k], last: (k == n - 1), empty: 1'b0};
              beats_due.push_back(beat);
            end
          end
        end
      end
      default: begin
        if (b == START_CHAR) frame_phase = PH_BODY;
        else frame_phase = PH_IDLE;
        stored = 0;
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit drain = 1'b0);
    rx_item_t it;
    it.data  = b;
    it.gap   = tx_calm ? 0 : $urandom_range(0, 4);
    it.drain = drain;
    rx_items.push_back(it);
  endtask

  // Monitor: sample both sides at the rising edge, check, predict, watchdog
  always @(posedge clk) begin
    cmd_beat_t want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_taken = 1'b1;
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected command byte %02h last=%0b empty=%0b",
                                    m_tdata, m_tlast, m_tuser));
        end else begin
          want = beats_due.pop_front();
          if (m_tdata !== want.cmd)
            report_mismatch($sformatf("cmd_byte %02h, expected %02h", m_tdata, want.cmd));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last_byte %0b, expected %0b", m_tlast, want.last));
          if (m_tuser !== want.empty)
            report_mismatch($sformatf("empty_command %0b, expected %0b", m_tuser, want.empty));
        end
      end
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        deframe_byte(s_tdata);
      end
      if (in_taken || out_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Driver: present the next byte at the falling edge once the slot is free
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (rx_items.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (rx_items[0].gap > 0) begin
        rx_items[0].gap = rx_items[0].gap - 1;
        s_tvalid <= 1'b0;
      end else if (rx_items[0].drain && beats_due.size() != 0) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tdata  <= rx_items[0].data;
        s_tvalid <= 1'b1;
        void'(rx_items.pop_front());
      end
    end
  end

  // Receiver: random stall after each accepted command byte, calm stretches now and then
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        sink_stall = sink_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 47) == 0) sink_calm = !sink_calm;
      end else if (sink_stall != 0 && m_tvalid) begin
        sink_stall--;
      end
      m_tready <= (sink_stall == 0);
    end
  end

  // Stimulus and end of test
  initial begin
    int frame_bytes;
    int frame_no;
    int len;
    int kind;
    logic [7:0] b;

    // Empty command
    push_byte(START_CHAR); push_byte(CR_CHAR); push_byte(LF_CHAR);
    // One byte, all ones
    push_byte(START_CHAR); push_byte(8'hFF); push_byte(CR_CHAR); push_byte(LF_CHAR);
    // Zero byte and a start char stored as payload
    push_byte(START_CHAR); push_byte(8'h00); push_byte(START_CHAR);
    push_byte(CR_CHAR); push_byte(LF_CHAR);
    // Bad terminator that is a start char: it must not open a frame
    push_byte(START_CHAR); push_byte(8'h5A); push_byte(CR_CHAR); push_byte(START_CHAR);
    push_byte(8'h41); push_byte(CR_CHAR); push_byte(LF_CHAR);
    // Terminators while idle
    push_byte(CR_CHAR); push_byte(LF_CHAR);
    // Empty frame with a bad terminator
    push_byte(START_CHAR); push_byte(CR_CHAR); push_byte(8'h00);

    // Random frames; first a full-length one, then one that overflows
    frame_bytes = 0;
    frame_no = 0;
    while (frame_bytes < 420) begin
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      if (frame_no == 0) len = STORE_DEPTH;
      else if (frame_no == 1) len = STORE_DEPTH + 1;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(0, STORE_DEPTH + 2);
      else len = $urandom_range(0, 8);
      kind = $urandom_range(0, 9);

      push_byte(START_CHAR, frame_no == 0 || frame_no == 20);
      for (int k = 0; k < len; k++) begin
        b = 8'($urandom_range(0, 255));
        if (b == CR_CHAR) b = 8'hF2;
        push_byte(b);
      end
      if (kind < 8) begin
        push_byte(CR_CHAR);
        push_byte(LF_CHAR);
      end else if (kind == 8) begin
        b = 8'($urandom_range(0, 255));
        if (b == LF_CHAR) b = START_CHAR;
        push_byte(CR_CHAR);
        push_byte(b);
      end
      // line noise between frames
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      frame_bytes += len + 3;
      frame_no++;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (rx_items.size() != 0 || s_tvalid) @(negedge clk);
    while (beats_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (beats_due.size() != 0)
      report_mismatch($sformatf("%0d command bytes never delivered", beats_due.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
